// File: sv/bvg_pkg.sv
package bvg_pkg;

  localparam int RegCount    = 8;
  localparam int CfgAddrBits = 5;
  localparam int RegBits     = 16;

  typedef logic [RegBits-1:0] reg_word_t;

  typedef enum logic [2:0] {
    REG_FAULT_LOW  = 3'd0,
    REG_FAULT_HIGH = 3'd1,
    REG_EMPTY      = 3'd2,
    REG_CRITICAL   = 3'd3,
    REG_LOW        = 3'd4,
    REG_MID        = 3'd5,
    REG_PCT_GAIN   = 3'd6,
    REG_MV_GAIN    = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    LEVEL_FAULT    = 3'd0,
    LEVEL_CRITICAL = 3'd1,
    LEVEL_LOW      = 3'd2,
    LEVEL_MID      = 3'd3,
    LEVEL_MAX      = 3'd4
  } level_t;

  typedef struct packed {
    reg_word_t fault_low;
    reg_word_t fault_high;
    reg_word_t empty;
    reg_word_t critical_top;
    reg_word_t low_top;
    reg_word_t mid_top;
    reg_word_t percent_gain;
    reg_word_t millivolt_gain;
  } cfg_t;

  function automatic reg_word_t reg_reset(input reg_idx_t idx);
    reg_word_t val;
    case (idx)
      REG_FAULT_LOW:  val = 16'd50680;
      REG_FAULT_HIGH: val = 16'd65535;
      REG_EMPTY:      val = 16'd51979;
      REG_CRITICAL:   val = 16'd54686;
      REG_LOW:        val = 16'd57395;
      REG_MID:        val = 16'd60103;
      REG_PCT_GAIN:   val = 16'd484;
      REG_MV_GAIN:    val = 16'd16504;
      default:        val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: sv/bvg_result.sv
module bvg_result #(
  parameter int AVG_BITS = 16
) (
  input  logic [AVG_BITS-1:0] average,
  input  bvg_pkg::cfg_t       cfg,
  output logic [15:0]         average_code,
  output logic [15:0]         voltage_mv,
  output logic signed [7:0]   charge_percent,
  output bvg_pkg::level_t     level
);
  import bvg_pkg::*;

  localparam int EXT_BITS = (AVG_BITS > RegBits) ? AVG_BITS : RegBits;
  localparam int MV_BITS  = AVG_BITS + RegBits;
  localparam int PCT_BITS = EXT_BITS + RegBits + 2;

  logic [EXT_BITS-1:0]        avg_ext;
  logic [MV_BITS-1:0]         mv_prod;
  logic [EXT_BITS-1:0]        mv_ext;
  logic signed [EXT_BITS:0]   pct_diff;
  logic signed [PCT_BITS-1:0] pct_prod;
  logic signed [PCT_BITS-1:0] pct_q;

  assign avg_ext      = EXT_BITS'(average);
  assign average_code = avg_ext[15:0];

  assign mv_prod    = MV_BITS'(average) * MV_BITS'(cfg.millivolt_gain);
  assign mv_ext     = EXT_BITS'(mv_prod[MV_BITS-1:RegBits]);
  assign voltage_mv = (|(mv_ext >> RegBits)) ? 16'hFFFF : mv_ext[15:0];

  assign pct_diff = $signed({1'b0, avg_ext}) - $signed({1'b0, EXT_BITS'(cfg.empty)});
  assign pct_prod = PCT_BITS'(pct_diff) * $signed(PCT_BITS'(cfg.percent_gain));
  assign pct_q    = pct_prod >>> RegBits;

  always_comb begin
    if (pct_q > $signed(PCT_BITS'(127))) begin
      charge_percent = 8'sd127;
    end else if (pct_q < -$signed(PCT_BITS'(128))) begin
      charge_percent = -8'sd128;
    end else begin
      charge_percent = pct_q[7:0];
    end
  end

  always_comb begin
    if (avg_ext < EXT_BITS'(cfg.fault_low) || avg_ext > EXT_BITS'(cfg.fault_high)) begin
      level = LEVEL_FAULT;
    end else if (avg_ext <= EXT_BITS'(cfg.critical_top)) begin
      level = LEVEL_CRITICAL;
    end else if (avg_ext <= EXT_BITS'(cfg.low_top)) begin
      level = LEVEL_LOW;
    end else if (avg_ext <= EXT_BITS'(cfg.mid_top)) begin
      level = LEVEL_MID;
    end else begin
      level = LEVEL_MAX;
    end
  end

endmodule

// File: sv/battery_voltage_gauge.sv
// Battery voltage gauge. Each request on the input channel carries one raw ADC
// sample; each one yields exactly one request on the output channel with the
// smoothed average, the voltage in millivolts, the charge percent and a level.
// The first sample after reset loads the average directly; later samples move
// it by one sixteenth (with the default shift) of the distance to the sample.
// A sample is taken at an edge where in_valid is high and in_stall is low. The
// average is updated at that edge; the result is then registered in the output
// register, which raises out_valid, as soon as out_stall lets it move.
// Throughput is one request per cycle while out_stall is low; the single average
// register is the loop that sets this rate. When the receiver raises out_stall,
// the result holds in the output register, one more sample can wait in the
// average stage, and then in_stall stays high until out_stall falls.
// Reset (rst_n low at a clock edge) clears both stages, forgets the average and
// loads the eight configuration registers with their default values. The
// registers sit on the APB port at byte addresses 0 to 28 and should be written
// only while no request is in flight.
module battery_voltage_gauge #(
  parameter int SAMPLE_BITS   = 12,
  parameter int AVERAGE_SHIFT = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [15:0]                      out_average_code,
  output logic [15:0]                      out_voltage_mv,
  output logic signed [7:0]                out_charge_percent,
  output logic [2:0]                       out_level,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bvg_pkg::CfgAddrBits-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import bvg_pkg::*;

  localparam int AVG_BITS = SAMPLE_BITS + AVERAGE_SHIFT;

  reg_word_t cfg_r [RegCount];
  cfg_t      cfg;
  logic      cfg_write;
  reg_idx_t  cfg_idx;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[CfgAddrBits-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {16'd0, cfg_r[cfg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RegCount; i++) begin
        cfg_r[i] <= reg_reset(reg_idx_t'(3'(i)));
      end
    end else if (cfg_write) begin
      cfg_r[cfg_idx] <= pwdata[RegBits-1:0];
    end
  end

  assign cfg.fault_low      = cfg_r[REG_FAULT_LOW];
  assign cfg.fault_high     = cfg_r[REG_FAULT_HIGH];
  assign cfg.empty          = cfg_r[REG_EMPTY];
  assign cfg.critical_top   = cfg_r[REG_CRITICAL];
  assign cfg.low_top        = cfg_r[REG_LOW];
  assign cfg.mid_top        = cfg_r[REG_MID];
  assign cfg.percent_gain   = cfg_r[REG_PCT_GAIN];
  assign cfg.millivolt_gain = cfg_r[REG_MV_GAIN];

  logic                       primed_r;
  logic                       avg_valid_r;
  logic                       avg_valid_nxt;
  logic [AVG_BITS-1:0]        avg_r;
  logic [AVG_BITS-1:0]        avg_nxt;
  logic [AVG_BITS-1:0]        target;
  logic signed [AVG_BITS+1:0] diff;
  logic signed [AVG_BITS+1:0] step;
  logic signed [AVG_BITS+1:0] sum;
  logic                       in_accept;
  logic                       out_ready;
  logic                       out_valid_r;

  assign target = {in_sample, {AVERAGE_SHIFT{1'b0}}};
  assign diff   = $signed({2'b00, target}) - $signed({2'b00, avg_r});
  assign step   = diff >>> AVERAGE_SHIFT;
  assign sum    = $signed({2'b00, avg_r}) + step;

  always_comb begin
    if (!primed_r) begin
      avg_nxt = target;
    end else if (sum[AVG_BITS+1]) begin
      avg_nxt = '0;
    end else begin
      avg_nxt = sum[AVG_BITS-1:0];
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = avg_valid_r && !out_ready;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      avg_valid_nxt = 1'b1;
    end else if (out_ready) begin
      avg_valid_nxt = 1'b0;
    end else begin
      avg_valid_nxt = avg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      avg_valid_r <= 1'b0;
      avg_r       <= '0;
    end else begin
      avg_valid_r <= avg_valid_nxt;
      if (in_accept) begin
        avg_r    <= avg_nxt;
        primed_r <= 1'b1;
      end
    end
  end

  logic [15:0]       res_average_code;
  logic [15:0]       res_voltage_mv;
  logic signed [7:0] res_charge_percent;
  level_t            res_level;

  bvg_result #(
    .AVG_BITS(AVG_BITS)
  ) u_result (
    .average       (avg_r),
    .cfg           (cfg),
    .average_code  (res_average_code),
    .voltage_mv    (res_voltage_mv),
    .charge_percent(res_charge_percent),
    .level         (res_level)
  );

  logic [15:0]       out_average_code_r;
  logic [15:0]       out_voltage_mv_r;
  logic signed [7:0] out_charge_percent_r;
  level_t            out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= avg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && avg_valid_r) begin
      out_average_code_r   <= res_average_code;
      out_voltage_mv_r     <= res_voltage_mv;
      out_charge_percent_r <= res_charge_percent;
      out_level_r          <= res_level;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_average_code   = out_average_code_r;
  assign out_voltage_mv     = out_voltage_mv_r;
  assign out_charge_percent = out_charge_percent_r;
  assign out_level          = 3'(out_level_r);

  a_primed_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> primed_r)
    else $error("Average not marked primed after a request.");

  a_first_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !primed_r) |=> (avg_r == $past(target)))
    else $error("First sample did not load the average directly.");

  a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (avg_valid_r && out_valid_r))
    else $error("Input stalled while the pipeline has room.");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (avg_valid_r && out_ready) |=> out_valid_r)
    else $error("Average stage did not move into the output register.");

endmodule
